/* rtl/cfeh_pkg.sv */
package cfeh_pkg;

  localparam int BYTE_W      = 8;
  localparam int HASH_W      = 28;
  localparam int TSIZE_W     = 16;
  localparam int CNT_W       = $clog2(HASH_W);
  localparam int APB_AW      = 2;
  localparam int APB_DW      = 32;

  localparam logic [TSIZE_W-1:0] TSIZE_RESET = TSIZE_W'(127);
  localparam logic [CNT_W-1:0]   CNT_LAST    = CNT_W'(HASH_W - 1);

  localparam logic [BYTE_W-1:0] UPPER_A   = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_Z   = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_DIFF = 8'h20;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } cfeh_state_t;

  typedef struct packed {
    logic hash_en;
    logic div_start;
    logic div_step;
    logic out_load;
  } cfeh_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_full;
  } cfeh_sts_t;

  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
    if (b >= UPPER_A && b <= UPPER_Z) begin
      return b + CASE_DIFF;
    end
    return b;
  endfunction

  // h = (h << 4) + c; top nibble xored back at bits 7:4, then dropped
  function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
    logic [HASH_W+3:0] x;
    logic [3:0]        g;
    x = {h, 4'b0000} + {24'd0, fold_case(b)};
    g = x[HASH_W+3:HASH_W];
    return x[HASH_W-1:0] ^ {20'd0, g, 4'b0000};
  endfunction

endpackage

/* rtl/case_folded_elf_hash_bucket_top.sv */
// Key bytes: one transaction per cycle, no result.
// Closing transaction (tlast): bit-serial modulo of the 28-bit hash in ST_DIV, then
// ST_HOLD loads the bucket into the output register once that register is free;
// input is accepted again in the cycle after the load.
// The output register lets the next key stream in while a bucket waits.
// Synchronous active-high reset: hash 0, table_size 127, no output pending.
module case_folded_elf_hash_bucket_top
  import cfeh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] key_byte
  input  logic              s_axis_tuser,   // [0] has_byte
  input  logic              s_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // [15:0] bucket
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [TSIZE_W-1:0] table_size;
  cfeh_cmd_t          cmd;
  cfeh_sts_t          sts;

  assign pready = 1'b1;

  // single register, any address in range selects it
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TSIZE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[1:0] == 2'b00 || 1'b1)) begin
      table_size <= pwdata[TSIZE_W-1:0];
    end
  end

  assign prdata = {{(APB_DW-TSIZE_W){1'b0}}, table_size};

  cfeh_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_has_byte (s_axis_tuser),
    .in_last     (s_axis_tlast),
    .in_ready    (s_axis_tready),
    .sts         (sts),
    .cmd         (cmd)
  );

  cfeh_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .key_byte   (s_axis_tdata),
    .table_size (table_size),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_bucket (m_axis_tdata)
  );

  a_no_input_during_div: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !s_axis_tready)
    else $error("input accepted during modulo");

  a_start_then_step: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> cmd.div_step)
    else $error("modulo did not start");

  a_load_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_axis_tvalid)
    else $error("loaded bucket not presented");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("pending bucket overwritten");

endmodule

/* rtl/cfeh_dp.sv */
module cfeh_dp
  import cfeh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfeh_cmd_t          cmd,
  output cfeh_sts_t          sts,
  input  logic [BYTE_W-1:0]  key_byte,
  input  logic [TSIZE_W-1:0] table_size,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [TSIZE_W-1:0] out_bucket
);

  logic [HASH_W-1:0]  hash;
  logic [TSIZE_W-1:0] rem;
  logic [CNT_W-1:0]   cnt;
  logic [TSIZE_W:0]   rem_sh;
  logic [TSIZE_W:0]   divisor;
  logic [TSIZE_W-1:0] rem_next;
  logic [HASH_W-1:0]  hash_in;

  // restoring division, hash register doubles as dividend shifter
  assign rem_sh   = {rem, hash[HASH_W-1]};
  assign divisor  = {1'b0, table_size};
  assign rem_next = (rem_sh >= divisor) ? TSIZE_W'(rem_sh - divisor) : rem_sh[TSIZE_W-1:0];
  assign hash_in  = cmd.hash_en ? hash_step(hash, key_byte) : hash;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= '0;
      cnt  <= '0;
    end else if (cmd.div_start) begin
      hash <= hash_in;
      cnt  <= CNT_LAST;
    end else if (cmd.div_step) begin
      hash <= {hash[HASH_W-2:0], 1'b0};
      cnt  <= cnt - CNT_W'(1);
    end else if (cmd.hash_en) begin
      hash <= hash_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_bucket <= (table_size == '0) ? '0 : rem;
    end
  end

  assign sts.div_done = (cnt == '0);
  assign sts.out_full = out_valid && !out_ready;

endmodule

/* rtl/cfeh_ctrl.sv */
module cfeh_ctrl
  import cfeh_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_has_byte,
  input  logic      in_last,
  output logic      in_ready,
  input  cfeh_sts_t sts,
  output cfeh_cmd_t cmd
);

  cfeh_state_t state;
  cfeh_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.hash_en = in_valid && in_has_byte;
        if (in_valid && in_last) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
